/* src/rdp_pkg.sv */
// Shared types and codes for the RTCP XR DLRR round-trip parser.
// Depends on nothing; used by the top level, the front parser and the back end.
package rdp_pkg;

  // End-of-packet status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_XR    = 3'd1;
  localparam logic [2:0] ST_LEN_BIG   = 3'd2;
  localparam logic [2:0] ST_BLOCK_BIG = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // Result kinds on tuser
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Protocol constants
  localparam logic [7:0] XR_PACKET_TYPE = 8'd207;
  localparam logic [7:0] BT_DLRR        = 8'd5;
  localparam logic [3:0] BLK_HDR_LEN    = 4'd4;
  localparam logic [3:0] SUB_BLOCK_LEN  = 4'd12;
  localparam logic [2:0] HDR_LAST_POS   = 3'd7;
  localparam logic [9:0] MS_PER_SECOND  = 10'd1000;

  // Work handed from the front parser to the back end for one byte
  typedef struct packed {
    logic        has_report;
    logic [31:0] ssrc;
    logic [31:0] lrr;
    logic [31:0] dlrr;
    logic [31:0] now;
    logic        has_status;
    logic [2:0]  status;
  } rdp_entry_t;

endpackage

/* src/rtcp_xr_dlrr_rtt_parser.sv */
// Top level of the RTCP XR DLRR round-trip parser: front parser, result queue, back end.
// Depends on rdp_pkg, rdp_front, rdp_fifo and rdp_back.
//
//  channel   | dir | tdata (low bit up)                          | tuser       | tlast
//  s_axis    | in  | packet_byte 8, packet_length 16, now_ntp 32 | -           | last_byte
//  m_axis    | out | source_id 32, round_trip_ms 32, status 3    | result_kind | run_end
//
// One packet byte is accepted per cycle; the front parser keeps pace with the link
// and holds s_axis_tready low only while the result queue is full.
// A byte that ends a DLRR sub-block reaches m_axis through the result queue, stage 1 and
// the output register; a final byte that also ends a sub-block gives two results, report first.
// Reset (rst, synchronous) returns the parser to the common header and empties the
// queue and the back-end pipeline. A stalled m_axis holds its result; bytes keep
// flowing until the queue fills.
module rtcp_xr_dlrr_rtt_parser
  import rdp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // packet_byte, packet_length, now_ntp_compact
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // source_id, round_trip_ms, parse_status, zero pad
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast
);

  localparam int ENTRY_W = $bits(rdp_entry_t);

  logic               queue_full;
  logic               push;
  rdp_entry_t         push_entry;
  logic               q_valid;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_data;
  logic [31:0]        source_id;
  logic signed [31:0] round_trip_ms;
  logic [2:0]         parse_status;

  // Parse each request (one packet byte) and queue only bytes that produce results
  rdp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .packet_byte     (s_axis_tdata[7:0]),
    .packet_length   (s_axis_tdata[23:8]),
    .now_ntp_compact (s_axis_tdata[55:24]),
    .last_byte       (s_axis_tlast),
    .queue_full      (queue_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  // Decouple the parser from output stalls
  rdp_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (push_entry),
    .full     (queue_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // Compute the round-trip time and serialize report and status results
  rdp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (rdp_entry_t'(q_data)),
    .q_pop         (q_pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .result_kind   (m_axis_tuser),
    .source_id     (source_id),
    .round_trip_ms (round_trip_ms),
    .parse_status  (parse_status),
    .run_end       (m_axis_tlast)
  );

  // Pack result fields, low field first, padded to whole bytes
  assign m_axis_tdata = {5'b0, parse_status, round_trip_ms, source_id};

endmodule

/* src/rdp_front.sv */
// Front parser: walks the RTCP XR packet byte by byte and queues report/status work.
// Depends on rdp_pkg.
module rdp_front
  import rdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic [15:0] packet_length,
  input  logic [31:0] now_ntp_compact,
  input  logic        last_byte,
  input  logic        queue_full,
  output logic        push,
  output rdp_entry_t  push_entry
);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_BLKHDR = 6'b000010,
    PH_DLRR   = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_t;

  localparam logic [17:0] POS_MAX = '1;

  phase_t      phase, phase_next;
  logic [17:0] pos, pos_next;
  logic [17:0] decl_len, decl_len_next;
  logic [7:0]  blk_type, blk_type_next;
  logic [17:0] blk_end, blk_end_next;
  logic [3:0]  sub_idx, sub_idx_next;
  logic [95:0] shift, shift_next;
  logic [2:0]  err, err_next;

  logic        accept;
  logic [18:0] pos_inc;
  logic [18:0] len_calc;
  logic [19:0] end_calc;
  logic [3:0]  sub_inc;
  phase_t      after_block;
  logic        blk_over;
  logic        report;
  logic [2:0]  status;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign pos_inc  = {1'b0, pos} + 19'd1;
  assign len_calc = ({3'b0, shift_next[15:0]} + 19'd1) << 2;
  assign end_calc = {2'b0, pos} - 20'd3 + {1'b0, len_calc};
  assign sub_inc  = sub_idx + 4'd1;
  assign blk_over = pos_inc >= {1'b0, blk_end};
  assign after_block = ({1'b0, pos} + 19'd5 < {1'b0, decl_len}) ? PH_BLKHDR : PH_DONE;

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    decl_len_next = decl_len;
    blk_type_next = blk_type;
    blk_end_next  = blk_end;
    sub_idx_next  = sub_idx;
    shift_next    = {shift[87:0], packet_byte};
    err_next      = err;
    report        = 1'b0;
    status        = ST_OK;

    unique case (phase)
      PH_HEADER: begin
        if (pos == 18'd1 && packet_byte != XR_PACKET_TYPE) begin
          err_next   = ST_NOT_XR;
          phase_next = PH_ERROR;
        end else if (pos == 18'd3) begin
          if (len_calc > {3'b0, packet_length}) begin
            err_next   = ST_LEN_BIG;
            phase_next = PH_ERROR;
          end else begin
            decl_len_next = len_calc[17:0];
          end
        end else if (pos >= 18'(HDR_LAST_POS)) begin
          sub_idx_next = '0;
          phase_next   = after_block;
        end
      end
      PH_BLKHDR: begin
        if (sub_idx == '0) begin
          blk_type_next = packet_byte;
        end
        sub_idx_next = sub_inc;
        if (sub_inc >= BLK_HDR_LEN) begin
          sub_idx_next = '0;
          if (end_calc > {4'b0, packet_length}) begin
            err_next   = ST_BLOCK_BIG;
            phase_next = PH_ERROR;
          end else begin
            blk_end_next = end_calc[17:0];
            if (len_calc == 19'd4) begin
              phase_next = after_block;
            end else begin
              phase_next = (blk_type == BT_DLRR) ? PH_DLRR : PH_SKIP;
            end
          end
        end
      end
      PH_DLRR: begin
        sub_idx_next = sub_inc;
        if (sub_inc >= SUB_BLOCK_LEN) begin
          sub_idx_next = '0;
          report       = 1'b1;
        end
        if (blk_over) begin
          sub_idx_next = '0;
          phase_next   = after_block;
        end
      end
      PH_SKIP: begin
        if (blk_over) begin
          sub_idx_next = '0;
          phase_next   = after_block;
        end
      end
      default: begin
      end
    endcase

    pos_next = (pos < POS_MAX) ? pos_inc[17:0] : POS_MAX;

    if (phase_next == PH_ERROR) begin
      status = err_next;
    end else if (phase_next == PH_DONE) begin
      status = ST_OK;
    end else begin
      status = ST_TRUNC;
    end
  end

  // Drop a byte that causes nothing; queue the rest
  assign push = accept && (report || last_byte);
  assign push_entry = '{
    has_report: report,
    ssrc:       shift_next[95:64],
    lrr:        shift_next[63:32],
    dlrr:       shift_next[31:0],
    now:        now_ntp_compact,
    has_status: last_byte,
    status:     status
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      pos     <= '0;
      sub_idx <= '0;
      err     <= ST_OK;
    end else if (accept) begin
      if (last_byte) begin
        phase   <= PH_HEADER;
        pos     <= '0;
        sub_idx <= '0;
        err     <= ST_OK;
      end else begin
        phase   <= phase_next;
        pos     <= pos_next;
        sub_idx <= sub_idx_next;
        err     <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      decl_len <= decl_len_next;
      blk_type <= blk_type_next;
      blk_end  <= blk_end_next;
      shift    <= shift_next;
    end
  end

endmodule

/* src/rdp_fifo.sv */
// Short register queue between the front parser and the back end.
// Depends on nothing; entry width set by the instantiating module.
module rdp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* src/rdp_back.sv */
// Back end: turns queued work into round-trip reports and end-of-packet status results.
// Depends on rdp_pkg.
module rdp_back
  import rdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rdp_entry_t        q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [31:0]       source_id,
  output logic signed [31:0] round_trip_ms,
  output logic [2:0]        parse_status,
  output logic              run_end
);

  // Stage 1: time difference
  logic        s1_valid;
  logic        s1_has_report;
  logic [31:0] s1_ssrc;
  logic [31:0] s1_diff;
  logic        s1_has_status;
  logic [2:0]  s1_status;

  // Stage 2: output register
  logic              o_valid;
  logic              o_has_report;
  logic              o_rep_done;
  logic [31:0]       o_ssrc;
  logic signed [31:0] o_rtt;
  logic              o_has_status;
  logic [2:0]        o_status;

  logic signed [42:0] prod;
  logic               show_report;
  logic               fire, o_free, s1_free;

  assign show_report = o_has_report && !o_rep_done;
  assign fire        = o_valid && out_ready;
  assign o_free      = !o_valid || (fire && run_end);
  assign s1_free     = !s1_valid || o_free;
  assign q_pop       = q_valid && s1_free;

  // Floor of diff * 1000 / 65536 is an arithmetic shift of the product
  assign prod = $signed({{11{s1_diff[31]}}, s1_diff}) * $signed({33'b0, MS_PER_SECOND});

  assign out_valid     = o_valid;
  assign result_kind   = show_report ? KIND_REPORT : KIND_STATUS;
  assign source_id     = show_report ? o_ssrc : '0;
  assign round_trip_ms = show_report ? o_rtt : '0;
  assign parse_status  = show_report ? ST_OK : o_status;
  assign run_end       = !(show_report && o_has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      o_valid    <= 1'b0;
      o_rep_done <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= q_valid;
      end
      if (o_free) begin
        o_valid    <= s1_valid;
        o_rep_done <= 1'b0;
      end else if (fire) begin
        o_rep_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_has_report <= q_entry.has_report;
      s1_ssrc       <= q_entry.ssrc;
      s1_diff       <= q_entry.now - q_entry.lrr - q_entry.dlrr;
      s1_has_status <= q_entry.has_status;
      s1_status     <= q_entry.status;
    end
    if (o_free && s1_valid) begin
      o_has_report <= s1_has_report;
      o_ssrc       <= s1_ssrc;
      o_rtt        <= {{5{prod[42]}}, prod[42:16]};
      o_has_status <= s1_has_status;
      o_status     <= s1_status;
    end
  end

endmodule
